// File: rtl/prq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg
// Shared widths, operation and status codes and cell control type for the
// priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int KIND_BITS     = 2;
   localparam int TASK_BITS     = 4;
   localparam int PRIO_IN_BITS  = 8;
   localparam int STATUS_BITS   = 2;

   localparam logic [KIND_BITS-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_POP    = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic push;     // append or insert taken this cycle
      logic insert;   // push is a priority insert
      logic pop;      // head removed this cycle
   } cell_ctrl_type;

endpackage

// File: rtl/prq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_if
// Request and response channels of the priority ready queue, each a
// valid/ready handshake carrying one item.
// ----------------------------------------------------------------------------
interface prq_req_if;
   import prq_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [KIND_BITS-1:0]    kind;
   logic [TASK_BITS-1:0]    task_id;
   logic [PRIO_IN_BITS-1:0] task_priority;

   modport source (output valid, kind, task_id, task_priority, input ready);
   modport sink   (input valid, kind, task_id, task_priority, output ready);
endinterface

interface prq_rsp_if #(
   parameter int OCC_BITS = 5
);
   import prq_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [TASK_BITS-1:0]    popped_task;
   logic [PRIO_IN_BITS-1:0] popped_priority;
   logic                    popped_valid;
   logic [STATUS_BITS-1:0]  status;
   logic [OCC_BITS-1:0]     occupancy;

   modport source (output valid, popped_task, popped_priority, popped_valid, status,
                   occupancy, input ready);
   modport sink   (input valid, popped_task, popped_priority, popped_valid, status,
                   occupancy, output ready);
endinterface

// File: rtl/prq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_cell
// One queue slot. Compares the incoming priority, passes the insert-point
// flag on to the next slot and loads from its left or right neighbour or
// from the new item.
// ----------------------------------------------------------------------------
module prq_cell #(
   parameter int PRIO_BITS = 8
) (
   input  logic                           clock,
   input  prq_pkg::cell_ctrl_type         ctrl,
   input  logic                           occupied,
   input  logic                           tail,
   input  logic                           found_in,
   output logic                           found_out,
   input  logic [prq_pkg::TASK_BITS-1:0]  new_task,
   input  logic [PRIO_BITS-1:0]           new_prio,
   input  logic [prq_pkg::TASK_BITS-1:0]  left_task,
   input  logic [PRIO_BITS-1:0]           left_prio,
   input  logic [prq_pkg::TASK_BITS-1:0]  right_task,
   input  logic [PRIO_BITS-1:0]           right_prio,
   output logic [prq_pkg::TASK_BITS-1:0]  slot_task,
   output logic [PRIO_BITS-1:0]           slot_prio
);
   import prq_pkg::*;

   logic [TASK_BITS-1:0] task_ff, task_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic                 load;
   logic                 hit;

   assign hit       = ctrl.insert && occupied && (new_prio < prio_ff);
   assign found_out = found_in || hit;

   always_comb begin
      load    = 1'b0;
      task_in = task_ff;
      prio_in = prio_ff;
      if (ctrl.pop) begin
         load    = 1'b1;
         task_in = right_task;
         prio_in = right_prio;
      end else if (ctrl.push) begin
         if (ctrl.insert && found_in) begin
            load    = 1'b1;
            task_in = left_task;
            prio_in = left_prio;
         end else if (hit || tail) begin
            load    = 1'b1;
            task_in = new_task;
            prio_in = new_prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         task_ff <= task_in;
         prio_ff <= prio_in;
      end
   end

   assign slot_task = task_ff;
   assign slot_prio = prio_ff;

endmodule

// File: rtl/priority_ready_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue
// Ready queue of task identifiers held in a row of compare-and-shift cells,
// head in cell 0. Append, insert by priority (FIFO among equals) or pop.
// Response: registered, in the cycle after the request is accepted.
// Throughput: one item per cycle while responses are taken; the insert-point
// flag ripples through the row and the moving cells shift in the same cycle.
// Reset: synchronous; clears the entry count and the response valid flag.
// Slot contents are not reset and are read only after being written.
// ----------------------------------------------------------------------------
module priority_ready_queue #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   prq_req_if.sink   req_chan,
   prq_rsp_if.source rsp_chan
);
   import prq_pkg::*;

   localparam int CountBits = $clog2(QUEUE_DEPTH + 1);

   logic [CountBits-1:0]    count_ff, count_in;
   logic                    rsp_valid_ff;
   logic [TASK_BITS-1:0]    popped_task_ff, popped_task_in;
   logic [PRIO_IN_BITS-1:0] popped_prio_ff, popped_prio_in;
   logic                    popped_valid_ff, popped_valid_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;

   logic                    accept;
   logic                    is_full;
   logic                    is_empty;
   cell_ctrl_type           ctrl;
   logic [PRIORITY_BITS-1:0] new_prio;
   logic [PRIORITY_BITS+PRIO_IN_BITS-1:0] prio_in_wide;
   logic [PRIORITY_BITS+PRIO_IN_BITS-1:0] prio_out_wide;
   logic [31:0]             occ_wide;

   logic [TASK_BITS-1:0]     cell_task [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];
   logic                     found     [QUEUE_DEPTH+1];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_full        = (count_ff == CountBits'(QUEUE_DEPTH));
   assign is_empty       = (count_ff == '0);

   assign prio_in_wide = {{PRIORITY_BITS{1'b0}}, req_chan.task_priority};
   assign new_prio     = prio_in_wide[PRIORITY_BITS-1:0];

   always_comb begin
      ctrl.push   = accept && !is_full &&
                    (req_chan.kind == KIND_APPEND || req_chan.kind == KIND_INSERT);
      ctrl.insert = req_chan.kind == KIND_INSERT;
      ctrl.pop    = accept && !is_empty && (req_chan.kind == KIND_POP);
   end

   assign found[0] = 1'b0;

   for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
      logic [TASK_BITS-1:0]     left_task,  right_task;
      logic [PRIORITY_BITS-1:0] left_prio,  right_prio;

      if (j == 0) begin : g_head
         assign left_task = req_chan.task_id;
         assign left_prio = new_prio;
      end else begin : g_body
         assign left_task = cell_task[j-1];
         assign left_prio = cell_prio[j-1];
      end

      if (j == QUEUE_DEPTH - 1) begin : g_last
         assign right_task = cell_task[j];
         assign right_prio = cell_prio[j];
      end else begin : g_inner
         assign right_task = cell_task[j+1];
         assign right_prio = cell_prio[j+1];
      end

      prq_cell #(
         .PRIO_BITS (PRIORITY_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (CountBits'(j) < count_ff),
         .tail       (CountBits'(j) == count_ff),
         .found_in   (found[j]),
         .found_out  (found[j+1]),
         .new_task   (req_chan.task_id),
         .new_prio   (new_prio),
         .left_task  (left_task),
         .left_prio  (left_prio),
         .right_task (right_task),
         .right_prio (right_prio),
         .slot_task  (cell_task[j]),
         .slot_prio  (cell_prio[j])
      );
   end

   assign prio_out_wide = {{PRIO_IN_BITS{1'b0}}, cell_prio[0]};

   always_comb begin
      count_in        = count_ff;
      popped_task_in  = '0;
      popped_prio_in  = '0;
      popped_valid_in = 1'b0;
      status_in       = ST_OK;
      case (req_chan.kind)
         KIND_APPEND, KIND_INSERT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         KIND_POP: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in        = count_ff - 1'b1;
               popped_task_in  = cell_task[0];
               popped_prio_in  = prio_out_wide[PRIO_IN_BITS-1:0];
               popped_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         popped_task_ff  <= popped_task_in;
         popped_prio_ff  <= popped_prio_in;
         popped_valid_ff <= popped_valid_in;
         status_ff       <= status_in;
      end
   end

   assign occ_wide = 32'(count_ff);

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.popped_task     = popped_task_ff;
   assign rsp_chan.popped_priority = popped_prio_ff;
   assign rsp_chan.popped_valid    = popped_valid_ff;
   assign rsp_chan.status          = status_ff;
   assign rsp_chan.occupancy       = occ_wide[$bits(rsp_chan.occupancy)-1:0];

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item gave no response");

   a_pop_good: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.kind == KIND_POP && !is_empty
      |=> popped_valid_ff && status_ff == ST_OK && count_ff == $past(count_ff) - 1'b1)
      else $error("pop on non-empty queue mishandled");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      accept && is_full && (req_chan.kind == KIND_APPEND || req_chan.kind == KIND_INSERT)
      |=> status_ff == ST_FULL && $stable(count_ff))
      else $error("push into full queue not rejected");
`endif

endmodule
